@@ rtl/wmt_pkg.sv @@
package wmt_pkg;

  localparam int unsigned SAMPLE_IN_W = 32;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COUNT_W     = 4;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DROP,
    CELL_INSERT
  } cell_op_t;

  // Broadcast to every cell of the sorted chain.
  typedef struct packed {
    cell_op_t            op;
    logic                full;
    logic [SAMPLE_W-1:0] value;
  } cell_ctrl_t;

endpackage

@@ rtl/wmt_in_if.sv @@
interface wmt_in_if;
  logic                                valid;
  logic                                ready;
  logic [wmt_pkg::SAMPLE_IN_W-1:0]     sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

@@ rtl/wmt_out_if.sv @@
interface wmt_out_if;
  logic                           valid;
  logic                           ready;
  logic [wmt_pkg::SAMPLE_W-1:0]   median_value;
  logic [wmt_pkg::COUNT_W-1:0]    valid_count;

  modport source (output valid, output median_value, output valid_count, input ready);
  modport sink   (input valid, input median_value, input valid_count, output ready);
endinterface

@@ rtl/wmt_cell.sv @@
module wmt_cell #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AGE_W = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wmt_pkg::cell_ctrl_t          ctrl,
  // left neighbor (smaller values)
  input  logic                         left_valid,
  input  logic [wmt_pkg::SAMPLE_W-1:0] left_val,
  input  logic [AGE_W-1:0]             left_age,
  input  logic                         left_big,
  input  logic                         left_gone,
  // right neighbor (larger values)
  input  logic                         right_valid,
  input  logic [wmt_pkg::SAMPLE_W-1:0] right_val,
  input  logic [AGE_W-1:0]             right_age,
  // own contents
  output logic                         valid,
  output logic [wmt_pkg::SAMPLE_W-1:0] val,
  output logic [AGE_W-1:0]             age,
  output logic                         big,
  output logic                         gone
);

  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(DEPTH - 1);

  logic del;

  // oldest entry leaves only once the window is full
  assign del  = ctrl.full && valid && (age == AGE_OLDEST);
  assign gone = left_gone || del;
  // empty slots sort above everything
  assign big  = !valid || (val > ctrl.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctrl.op)
        wmt_pkg::CELL_DROP: begin
          if (gone) begin
            valid <= right_valid;
            val   <= right_val;
            age   <= right_age;
          end
        end
        wmt_pkg::CELL_INSERT: begin
          if (big && !left_big) begin
            valid <= 1'b1;
            val   <= ctrl.value;
            age   <= '0;
          end else if (big) begin
            valid <= left_valid;
            val   <= left_val;
            age   <= left_age + 1'b1;
          end else begin
            age   <= age + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/windowed_median_tracker.sv @@
// Running upper median over the last WINDOW_DEPTH samples. Each input beat
// carries a 32-bit response time, clipped to 65535, and yields exactly one
// output beat with the upper median (element count/2 of the sorted window)
// and the number of samples held so far, 1..WINDOW_DEPTH (low 4 bits).
// Samples live in a chain of cells kept in ascending order; every cell also
// tracks the age of its sample, so the ring order needs no separate pointer.
// Each item goes through accept, drop the oldest sample (window full only),
// sorted insert of the new one, median pick into the output register. The
// input is taken again while a result still waits on the output side.
module windowed_median_tracker #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  wmt_in_if.sink     sample_in,
  wmt_out_if.source  result_out
);

  localparam int unsigned AGE_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned IDX_W = AGE_W;
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DROP,
    ST_INSERT,
    ST_PICK
  } state_t;

  state_t state;

  logic [wmt_pkg::SAMPLE_W-1:0] sample;   // clipped sample under work
  logic [CNT_W-1:0]             fill;     // valid entries in the window

  wmt_pkg::cell_ctrl_t ctrl;

  // chain wiring, one entry per cell
  logic                         c_valid [WINDOW_DEPTH];
  logic [wmt_pkg::SAMPLE_W-1:0] c_val   [WINDOW_DEPTH];
  logic [AGE_W-1:0]             c_age   [WINDOW_DEPTH];
  logic                         c_big   [WINDOW_DEPTH];
  logic                         c_gone  [WINDOW_DEPTH];

  logic [IDX_W-1:0] mid_idx;
  logic [31:0]      fill_ext;
  logic             out_free;

  assign sample_in.ready = (state == ST_IDLE);

  always_comb begin
    ctrl.full  = (fill == CNT_FULL);
    ctrl.value = sample;
    unique case (state)
      ST_DROP:   ctrl.op = wmt_pkg::CELL_DROP;
      ST_INSERT: ctrl.op = wmt_pkg::CELL_INSERT;
      default:   ctrl.op = wmt_pkg::CELL_HOLD;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
      logic                         l_valid;
      logic [wmt_pkg::SAMPLE_W-1:0] l_val;
      logic [AGE_W-1:0]             l_age;
      logic                         l_big;
      logic                         l_gone;
      logic                         r_valid;
      logic [wmt_pkg::SAMPLE_W-1:0] r_val;
      logic [AGE_W-1:0]             r_age;

      if (gi == 0) begin : g_head
        // head of the chain: nothing smaller, nothing dropped before it
        assign l_valid = 1'b0;
        assign l_val   = '0;
        assign l_age   = '0;
        assign l_big   = 1'b0;
        assign l_gone  = 1'b0;
      end else begin : g_link_l
        assign l_valid = c_valid[gi-1];
        assign l_val   = c_val[gi-1];
        assign l_age   = c_age[gi-1];
        assign l_big   = c_big[gi-1];
        assign l_gone  = c_gone[gi-1];
      end

      if (gi == WINDOW_DEPTH - 1) begin : g_tail
        // tail: shifting down leaves an empty slot
        assign r_valid = 1'b0;
        assign r_val   = '0;
        assign r_age   = '0;
      end else begin : g_link_r
        assign r_valid = c_valid[gi+1];
        assign r_val   = c_val[gi+1];
        assign r_age   = c_age[gi+1];
      end

      wmt_cell #(
        .DEPTH (WINDOW_DEPTH),
        .AGE_W (AGE_W)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .left_valid  (l_valid),
        .left_val    (l_val),
        .left_age    (l_age),
        .left_big    (l_big),
        .left_gone   (l_gone),
        .right_valid (r_valid),
        .right_val   (r_val),
        .right_age   (r_age),
        .valid       (c_valid[gi]),
        .val         (c_val[gi]),
        .age         (c_age[gi]),
        .big         (c_big[gi]),
        .gone        (c_gone[gi])
      );
    end
  endgenerate

  // upper median sits at index fill/2 of the sorted chain
  assign mid_idx  = IDX_W'(fill >> 1);
  assign fill_ext = 32'(fill);
  assign out_free = !result_out.valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      fill             <= '0;
      result_out.valid <= 1'b0;
    end else begin
      // in the pick step a leaving result is replaced by the new one
      if (result_out.valid && result_out.ready && (state != ST_PICK)) begin
        result_out.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_in.valid) begin
            sample <= (|sample_in.sample_value[wmt_pkg::SAMPLE_IN_W-1:wmt_pkg::SAMPLE_W])
                      ? wmt_pkg::SAMPLE_MAX
                      : sample_in.sample_value[wmt_pkg::SAMPLE_W-1:0];
            state  <= ST_DROP;
          end
        end
        ST_DROP: begin
          state <= ST_INSERT;
        end
        ST_INSERT: begin
          if (fill != CNT_FULL) begin
            fill <= fill + 1'b1;
          end
          state <= ST_PICK;
        end
        ST_PICK: begin
          // wait here while the previous result is still unclaimed
          if (out_free) begin
            result_out.valid        <= 1'b1;
            result_out.median_value <= c_val[mid_idx];
            result_out.valid_count  <= fill_ext[wmt_pkg::COUNT_W-1:0];
            state                   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
